FILE: src/periodic_task_tick_scheduler_assert.svh
// Assertion macros used by the scheduler's task bank.
// Each expects signals named clk and rst_n in the module that uses it.
`ifndef PERIODIC_TASK_TICK_SCHEDULER_ASSERT_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTTS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PTTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ptts_pkg.sv
package ptts_pkg;

  // Bank size and the fixed field widths
  localparam int NUM_TASKS   = 4;
  localparam int SETUP_REGS  = 4;
  localparam int NUM_SEL     = 4;
  localparam int MASK_W      = 4;
  localparam int MASK_TASKS  = (NUM_TASKS < MASK_W) ? NUM_TASKS : MASK_W;
  localparam int TASK_IDX_W  = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int SETUP_W     = 33;
  localparam int PERIOD_W    = 16;
  localparam int OFFSET_LSB  = 16;
  localparam int CONT_BIT    = 32;
  localparam int CNT_W       = 17;
  localparam int OVR_W       = 32;

  // Operation codes
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_SERVICE = 1'b1;

  typedef logic [SETUP_W-1:0] setup_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [OVR_W-1:0]   ovr_t;

  // Request held in the input register
  typedef struct packed {
    logic                  vld;
    logic                  operation;
    logic [TASK_IDX_W-1:0] task_index;
  } item_t;

  // Result of one request
  typedef struct packed {
    logic [MASK_W-1:0] pending_mask;
    logic              dispatched;
    ovr_t              overrun_count;
  } result_t;

  // Counter load value: start offset plus reload period
  function automatic cnt_t start_value(input setup_t s);
    cnt_t reload;
    cnt_t offset;
    reload = CNT_W'(s[PERIOD_W-1:0]);
    offset = CNT_W'(s[OFFSET_LSB +: PERIOD_W]);
    return reload + offset;
  endfunction

endpackage

FILE: src/ptts_in_if.sv
interface ptts_in_if import ptts_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [TASK_IDX_W-1:0] task_index;

  modport source (output valid, output operation, output task_index, input ready);
  modport sink   (input valid, input operation, input task_index, output ready);
endinterface

FILE: src/ptts_out_if.sv
interface ptts_out_if import ptts_pkg::*;;
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] pending_mask;
  logic              dispatched;
  ovr_t              overrun_count;

  modport source (output valid, output pending_mask, output dispatched,
                  output overrun_count, input ready);
  modport sink   (input valid, input pending_mask, input dispatched,
                  input overrun_count, output ready);
endinterface

FILE: src/ptts_cfg_if.sv
interface ptts_cfg_if import ptts_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  setup_t               data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/ptts_in_stage.sv
module ptts_in_stage import ptts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ptts_in_if.sink    in_req,
  input  logic       advance,
  output item_t      item
);

  logic                  vld_r;
  logic                  op_r;
  logic [TASK_IDX_W-1:0] idx_r;
  logic                  take;

  // Accept a request when the register is empty or drains this cycle
  assign in_req.ready = !vld_r || advance;
  assign take         = in_req.valid && in_req.ready;

  // Hold the occupancy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= 1'b1;
    end else if (advance) begin
      vld_r <= 1'b0;
    end
  end

  // Capture the request payload
  always_ff @(posedge clk) begin
    if (take) begin
      op_r  <= in_req.operation;
      idx_r <= in_req.task_index;
    end
  end

  assign item = '{vld: vld_r, operation: op_r, task_index: idx_r};

endmodule

FILE: src/ptts_task_bank.sv
module ptts_task_bank import ptts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ptts_cfg_if.sink   cfg_wr,
  input  item_t      item,
  input  logic       advance,
  output result_t    res
);

  `include "periodic_task_tick_scheduler_assert.svh"

  setup_t [NUM_TASKS-1:0] setup_r;
  cnt_t   [NUM_TASKS-1:0] cnt_r;
  cnt_t   [NUM_TASKS-1:0] cnt_nxt;
  logic   [NUM_TASKS-1:0] pend_r;
  logic   [NUM_TASKS-1:0] pend_nxt;
  ovr_t   [NUM_TASKS-1:0] ovr_r;
  ovr_t   [NUM_TASKS-1:0] ovr_nxt;
  logic                   tick;
  logic                   svc;
  logic                   cfg_we;

  assign cfg_wr.ready = 1'b1;
  assign cfg_we       = cfg_wr.valid;
  assign tick         = advance && (item.operation == OP_TICK);
  assign svc          = advance && (item.operation == OP_SERVICE);

  // Next state of every task timer, all in parallel
  always_comb begin
    for (int i = 0; i < NUM_TASKS; i++) begin
      cnt_nxt[i]  = cnt_r[i];
      pend_nxt[i] = pend_r[i];
      ovr_nxt[i]  = ovr_r[i];
      if (tick && (cnt_r[i] != '0)) begin
        if (cnt_r[i] == CNT_W'(1)) begin
          // expiry: reload if continuous, count an overrun if already pending, raise pending
          cnt_nxt[i]  = setup_r[i][CONT_BIT] ? CNT_W'(setup_r[i][PERIOD_W-1:0]) : '0;
          if (pend_r[i]) begin
            ovr_nxt[i] = ovr_r[i] + OVR_W'(1);
          end
          pend_nxt[i] = 1'b1;
        end else begin
          cnt_nxt[i] = cnt_r[i] - CNT_W'(1);
        end
      end
      if (svc && (i < NUM_SEL) && (item.task_index == TASK_IDX_W'(i))) begin
        pend_nxt[i] = 1'b0;
      end
    end
  end

  // Form the result from the post-step state; dispatched uses the flag before the step
  always_comb begin
    res = '0;
    for (int i = 0; i < MASK_TASKS; i++) begin
      res.pending_mask[i] = pend_nxt[i];
    end
    for (int i = 0; i < NUM_TASKS; i++) begin
      if ((i < NUM_SEL) && (item.task_index == TASK_IDX_W'(i))) begin
        res.overrun_count = ovr_nxt[i];
        res.dispatched    = svc && pend_r[i];
      end
    end
  end

  // Update timer state; a setup write reloads only the counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setup_r <= '0;
      cnt_r   <= '0;
      pend_r  <= '0;
      ovr_r   <= '0;
    end else begin
      pend_r <= pend_nxt;
      ovr_r  <= ovr_nxt;
      for (int i = 0; i < NUM_TASKS; i++) begin
        if (cfg_we && (i < SETUP_REGS) && (cfg_wr.index == CFG_IDX_W'(i))) begin
          setup_r[i] <= cfg_wr.data;
          cnt_r[i]   <= start_value(cfg_wr.data);
        end else begin
          cnt_r[i]   <= cnt_nxt[i];
        end
      end
    end
  end

  // A tick never clears a pending flag
  `PTTS_ASSERT_NEXT(a_tick_no_clear, tick, (pend_r & $past(pend_r)) == $past(pend_r), "tick cleared a pending flag")
  // A service request never raises a flag and clears at most one
  `PTTS_ASSERT_NEXT(a_svc_one_clear, svc, ((pend_r & ~$past(pend_r)) == '0) && ($countones(pend_r ^ $past(pend_r)) <= 1), "service changed pending flags wrongly")
  // Overrun counters move only on ticks
  `PTTS_ASSERT_NEXT(a_ovr_only_tick, !tick, $stable(ovr_r), "overrun counter changed outside a tick")

endmodule

FILE: src/ptts_out_stage.sv
module ptts_out_stage import ptts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_vld,
  input  result_t    res,
  output logic       advance,
  ptts_out_if.source out_rsp
);

  logic    vld_r;
  result_t res_r;

  // Move the request forward when the result register is free or drains
  assign advance = item_vld && (!vld_r || out_rsp.ready);

  // Hold the result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= 1'b1;
    end else if (out_rsp.ready) begin
      vld_r <= 1'b0;
    end
  end

  // Capture the result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_rsp.valid         = vld_r;
  assign out_rsp.pending_mask  = res_r.pending_mask;
  assign out_rsp.dispatched    = res_r.dispatched;
  assign out_rsp.overrun_count = res_r.overrun_count;

endmodule

FILE: src/periodic_task_tick_scheduler.sv
// Bank of four periodic task timers. A tick request decrements every running
// counter; an expiring task raises its pending flag, counts an overrun if the
// flag was already up, and reloads if continuous. A service request clears one
// task's pending flag and reports whether it was set. Each request gives one
// result. Throughput is one request per clock when the output is not stalled:
// the request sits in an input register; when the output register is free or
// drains, the whole timer bank updates at a clock edge and the result lands in
// the output register at that same edge, where it is offered until taken.
// Setup writes are taken every cycle, reload the task's counter and take effect
// from the next cycle.
module periodic_task_tick_scheduler import ptts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ptts_in_if.sink    in_req,
  ptts_out_if.source out_rsp,
  ptts_cfg_if.sink   cfg_wr
);

  item_t   item;
  result_t res;
  logic    advance;

  ptts_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .advance (advance),
    .item    (item)
  );

  ptts_task_bank u_task_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_wr  (cfg_wr),
    .item    (item),
    .advance (advance),
    .res     (res)
  );

  ptts_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (item.vld),
    .res      (res),
    .advance  (advance),
    .out_rsp  (out_rsp)
  );

endmodule

FILE: verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptts_pkg::*;

  localparam int LIMIT_CYCLES = 800_000;
  localparam int LONG_HOLD    = 300;
  localparam int NUM_PHASES   = 15;
  localparam int PHASE_ITEMS  = 103;
  localparam int SETTLE       = 10;

  // Configuration register map
  localparam logic [CFG_IDX_W-1:0] REG_TASK0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TASK1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TASK2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TASK3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TOP      = 3'd7;

  // One line of the directed script: a setup write or a request
  typedef struct {
    bit                    is_setup;
    logic [CFG_IDX_W-1:0]  reg_idx;
    setup_t                setup_val;
    logic                  op;
    logic [TASK_IDX_W-1:0] task_idx;
    bit                    known;
    result_t               want;
  } script_line_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ptts_in_if  in_ch ();
  ptts_out_if out_ch ();
  ptts_cfg_if cfg_ch ();

  periodic_task_tick_scheduler u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_ch),
    .out_rsp (out_ch),
    .cfg_wr  (cfg_ch)
  );

  // Shadow of the timer bank
  setup_t task_setup [NUM_TASKS];
  cnt_t   timer_cnt  [NUM_TASKS];
  logic   pend       [NUM_TASKS];
  ovr_t   overruns   [NUM_TASKS];

  result_t      due_results [$];
  script_line_t script [$];
  int           mismatches;
  int           cycles;
  bit           quiet_phase;
  bit           pressure_armed;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones, none in a quiet phase
  function automatic int pick_gap();
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Apply a setup write to the shadow bank; counter reloads, flags stay
  function automatic void load_setup(input logic [CFG_IDX_W-1:0] idx, input setup_t val);
    if (idx >= SETUP_REGS || idx >= NUM_TASKS) return;
    task_setup[idx] = val;
    timer_cnt[idx]  = CNT_W'(val[PERIOD_W-1:0]) + CNT_W'(val[OFFSET_LSB +: PERIOD_W]);
  endfunction

  // Advance the shadow bank by one request and return its result
  function automatic result_t schedule_step(input logic op,
                                            input logic [TASK_IDX_W-1:0] sel);
    result_t r;
    r = '0;
    if (op == OP_TICK) begin
      for (int t = 0; t < NUM_TASKS; t++) begin
        if (timer_cnt[t] != '0) begin
          timer_cnt[t] = timer_cnt[t] - 1'b1;
          if (timer_cnt[t] == '0) begin
            if (task_setup[t][CONT_BIT]) timer_cnt[t] = CNT_W'(task_setup[t][PERIOD_W-1:0]);
            if (pend[t]) overruns[t] = overruns[t] + 1'b1;
            pend[t] = 1'b1;
          end
        end
      end
    end else if (sel < NUM_TASKS) begin
      if (pend[sel]) begin
        pend[sel]    = 1'b0;
        r.dispatched = 1'b1;
      end
    end
    for (int t = 0; t < MASK_TASKS; t++) r.pending_mask[t] = pend[t];
    if (sel < NUM_TASKS) r.overrun_count = overruns[sel];
    return r;
  endfunction

  function automatic setup_t random_setup(input int mode);
    setup_t s;
    s = '0;
    case (mode)
      0: s = '1;
      1: s[CONT_BIT] = 1'($urandom_range(0, 1));
      2, 3: begin
        s[CONT_BIT-1:0] = $urandom();
        s[CONT_BIT]     = 1'($urandom_range(0, 1));
      end
      default: begin
        s[PERIOD_W-1:0]           = PERIOD_W'($urandom_range(0, 9));
        s[OFFSET_LSB +: PERIOD_W] = PERIOD_W'($urandom_range(0, 12));
        s[CONT_BIT]               = ($urandom_range(0, 3) != 0);
      end
    endcase
    return s;
  endfunction

  // Script builders
  function automatic void add_setup(input logic [CFG_IDX_W-1:0] idx, input setup_t val);
    script_line_t l;
    l = '{default: '0};
    l.is_setup  = 1'b1;
    l.reg_idx   = idx;
    l.setup_val = val;
    script.push_back(l);
  endfunction

  function automatic void add_req(input logic op, input logic [TASK_IDX_W-1:0] idx);
    script_line_t l;
    l = '{default: '0};
    l.op       = op;
    l.task_idx = idx;
    script.push_back(l);
  endfunction

  function automatic void add_known(input logic op, input logic [TASK_IDX_W-1:0] idx,
                                    input logic [MASK_W-1:0] mask, input logic disp,
                                    input ovr_t ovr);
    script_line_t l;
    l = '{default: '0};
    l.op                 = op;
    l.task_idx           = idx;
    l.known              = 1'b1;
    l.want.pending_mask  = mask;
    l.want.dispatched    = disp;
    l.want.overrun_count = ovr;
    script.push_back(l);
  endfunction

  // Offer one request, wait for it to be taken, then log its result
  task automatic push_request(input logic op, input logic [TASK_IDX_W-1:0] idx,
                              input bit known, input result_t want);
    int      gap;
    result_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.task_index <= idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = schedule_step(op, idx);
    due_results.push_back(known ? want : predicted);
  endtask

  // Drop the request line and let the bank drain
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_setup(input logic [CFG_IDX_W-1:0] idx, input setup_t val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    load_setup(idx, val);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off when armed
  initial begin : result_sink
    int stall;
    forever begin
      if (pressure_armed) begin
        pressure_armed = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  task automatic check_field(input string name, input logic [OVR_W-1:0] want,
                             input logic [OVR_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each result with the oldest outstanding expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_results.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        want = due_results.pop_front();
        check_field("pending_mask", OVR_W'(want.pending_mask), OVR_W'(out_ch.pending_mask));
        check_field("dispatched", OVR_W'(want.dispatched), OVR_W'(out_ch.dispatched));
        check_field("overrun_count", want.overrun_count, out_ch.overrun_count);
      end
    end
  end

  initial begin : stimulus
    int mode;
    in_ch.valid      <= 1'b0;
    in_ch.operation  <= OP_TICK;
    in_ch.task_index <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= REG_TASK0;
    cfg_ch.data      <= '0;
    mismatches     = 0;
    cycles         = 0;
    quiet_phase    = 1'b0;
    pressure_armed = 1'b0;
    for (int t = 0; t < NUM_TASKS; t++) begin
      task_setup[t] = '0;
      timer_cnt[t]  = '0;
      pend[t]       = 1'b0;
      overruns[t]   = '0;
    end

    // Idle bank after reset
    add_known(OP_TICK,    2'd0, 4'b0000, 1'b0, 32'd0);
    add_known(OP_SERVICE, 2'd3, 4'b0000, 1'b0, 32'd0);
    // Continuous period 1; one-shot 1+2; continuous zero period; all ones
    add_setup(REG_TASK0, 33'h1_0000_0001);
    add_setup(REG_TASK1, 33'h0_0001_0002);
    add_setup(REG_TASK2, 33'h1_0002_0000);
    add_setup(REG_TASK3, 33'h1_FFFF_FFFF);
    // Write to an unmapped index must not touch any task
    add_setup(REG_UNMAPPED, 33'h1_0000_0001);
    add_known(OP_TICK,    2'd0, 4'b0001, 1'b0, 32'd0);
    add_known(OP_TICK,    2'd0, 4'b0101, 1'b0, 32'd1);
    add_known(OP_TICK,    2'd2, 4'b0111, 1'b0, 32'd0);
    add_known(OP_SERVICE, 2'd0, 4'b0110, 1'b1, 32'd2);
    add_known(OP_SERVICE, 2'd0, 4'b0110, 1'b0, 32'd2);
    add_known(OP_TICK,    2'd1, 4'b0111, 1'b0, 32'd0);
    add_known(OP_SERVICE, 2'd1, 4'b0101, 1'b1, 32'd0);
    add_known(OP_SERVICE, 2'd2, 4'b0001, 1'b1, 32'd0);
    add_known(OP_SERVICE, 2'd3, 4'b0001, 1'b0, 32'd0);
    // Rewrite keeps pending flag and overrun count
    add_setup(REG_TASK0, 33'h0_0000_0000);
    add_known(OP_TICK,    2'd0, 4'b0001, 1'b0, 32'd2);
    add_known(OP_SERVICE, 2'd0, 4'b0000, 1'b1, 32'd2);
    add_setup(REG_TASK1, 33'h0_FFFF_FFFF);
    add_req(OP_TICK,    2'd3);
    add_req(OP_SERVICE, 2'd1);
    add_req(OP_TICK,    2'd1);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed script
    foreach (script[k]) begin
      if (script[k].is_setup) begin
        wait_idle();
        write_setup(script[k].reg_idx, script[k].setup_val);
      end else begin
        push_request(script[k].op, script[k].task_idx, script[k].known, script[k].want);
      end
    end

    // Random phases, each with fresh task settings
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      for (int t = 0; t < SETUP_REGS; t++) begin
        mode = (ph == 0) ? 0 : (ph == 1) ? 1 : $urandom_range(0, 9);
        write_setup(CFG_IDX_W'(t), random_setup(mode));
      end
      if ($urandom_range(0, 2) == 0)
        write_setup(CFG_IDX_W'($urandom_range(SETUP_REGS, REG_TOP)), random_setup(2));
      quiet_phase = (ph % 4 == 3);
      if (ph == 2) pressure_armed = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        push_request(($urandom_range(0, 99) < 65) ? OP_TICK : OP_SERVICE,
                     TASK_IDX_W'($urandom_range(0, 3)), 1'b0, '0);
      end
    end

    quiet_phase = 1'b0;
    wait_idle();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
